/* hw/rtl/srs_pkg.sv */
// Shared types, codes and constants of the servo recipe sequencer.
package srs_pkg;

    localparam int RECIPE_DEPTH_DEFAULT = 64;

    localparam int OP_W      = 3;
    localparam int ADDR_IN_W = 6;
    localparam int WORD_W    = 8;
    localparam int PARAM_W   = 5;
    localparam int DUTY_W    = 8;
    localparam int POS_W     = 3;
    localparam int INDEX_W   = 6;
    localparam int TICK_W    = 7;
    localparam int MTICK_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_VAL_W = 4;

    localparam logic [POS_W-1:0]     POS_MAX          = 3'd5;
    localparam logic [CFG_VAL_W-1:0] MOVE_TICKS_RESET = 4'd2;
    localparam logic [CFG_VAL_W-1:0] MAN_TICKS_RESET  = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOVE_TICKS   = 2'd0,
        CFG_MANUAL_TICKS = 2'd1
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_WRITE    = 3'd1,
        OP_PAUSE    = 3'd2,
        OP_CONTINUE = 3'd3,
        OP_STEP_R   = 3'd4,
        OP_STEP_L   = 3'd5,
        OP_RESTART  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        OPC_END     = 3'd0,
        OPC_MOV     = 3'd1,
        OPC_WAIT    = 3'd2,
        OPC_LOOP    = 3'd4,
        OPC_ENDLOOP = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_PAUSED   = 3'd0,
        ST_RUNNING  = 3'd1,
        ST_MOVING   = 3'd2,
        ST_CMD_ERR  = 3'd3,
        ST_NEST_ERR = 3'd4,
        ST_FINISHED = 3'd5,
        ST_MANUAL   = 3'd6
    } status_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_value;
        status_t            run_state;
        logic [POS_W-1:0]   servo_position;
        logic [INDEX_W-1:0] program_index;
    } result_t;

    // PWM compare value for a position: 40 + 32 * position.
    function automatic logic [DUTY_W-1:0] duty_of(input logic [POS_W-1:0] pos);
        logic [DUTY_W-1:0] d;
        unique case (pos)
            3'd0:    d = 8'd40;
            3'd1:    d = 8'd72;
            3'd2:    d = 8'd104;
            3'd3:    d = 8'd136;
            3'd4:    d = 8'd168;
            3'd5:    d = 8'd200;
            default: d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

/* hw/rtl/srs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module srs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/srs_core.sv */
// Sequencer state, command execution and recipe fetch with write bypass.
module srs_core #(
    parameter int RECIPE_DEPTH = srs_pkg::RECIPE_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_fire,
    input  logic [srs_pkg::OP_W-1:0]          operation,
    input  logic [srs_pkg::ADDR_IN_W-1:0]     recipe_address,
    input  logic [srs_pkg::WORD_W-1:0]        recipe_word,
    input  logic                              cfg_write,
    input  logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srs_pkg::CFG_VAL_W-1:0]     cfg_data,
    output logic                              ram_we,
    output logic [$clog2(RECIPE_DEPTH)-1:0]   ram_waddr,
    output logic [srs_pkg::WORD_W-1:0]        ram_wdata,
    output logic [$clog2(RECIPE_DEPTH)-1:0]   ram_raddr,
    input  logic [srs_pkg::WORD_W-1:0]        ram_rdata,
    output srs_pkg::result_t                  result
);

    localparam int AW = $clog2(RECIPE_DEPTH);
    localparam logic [AW-1:0] LAST_INDEX = AW'(RECIPE_DEPTH - 1);

    logic [AW-1:0]                     pc_reg, pc_next;
    logic [srs_pkg::TICK_W-1:0]        tick_reg, tick_next;
    logic [AW-1:0]                     loop_start_reg, loop_start_next;
    logic [srs_pkg::PARAM_W-1:0]       loop_rem_reg, loop_rem_next;
    logic                              loop_act_reg, loop_act_next;
    logic                              pend_reg, pend_next;
    srs_pkg::status_t                  status_reg, status_next;
    logic [srs_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [srs_pkg::MTICK_W-1:0]       mtc_reg, mtc_next;
    logic [srs_pkg::DUTY_W-1:0]        duty_reg, duty_next;
    logic [srs_pkg::CFG_VAL_W-1:0]     move_ticks_reg, man_ticks_reg;
    logic                              byp_hit_reg;
    logic [srs_pkg::WORD_W-1:0]        byp_word_reg;
    logic [RECIPE_DEPTH-1:0]           valid_reg;

    logic [srs_pkg::WORD_W-1:0]        cmd;
    logic [srs_pkg::PARAM_W-1:0]       par;
    logic [srs_pkg::POS_W-1:0]         par_pos;
    logic [srs_pkg::POS_W-1:0]         pos_gap;
    logic [srs_pkg::TICK_W-1:0]        target;
    logic [srs_pkg::MTICK_W-1:0]       mtc_inc;
    logic [AW-1:0]                     pc_inc, loop_inc;
    logic [8:0]                        addr_ext;
    logic [8:0]                        index_ext;
    logic                              stopped;

    // Current command: bypass a write that landed on the fetched entry,
    // and read never-written entries as END.
    assign cmd = byp_hit_reg ? byp_word_reg :
                 (valid_reg[pc_reg] ? ram_rdata : '0);
    assign par     = cmd[srs_pkg::PARAM_W-1:0];
    assign par_pos = par[srs_pkg::POS_W-1:0];
    assign pos_gap = (par_pos > pos_reg) ? par_pos - pos_reg : pos_reg - par_pos;
    assign target  = srs_pkg::TICK_W'(move_ticks_reg) * srs_pkg::TICK_W'(pos_gap);
    assign mtc_inc = mtc_reg + 4'd1;
    assign pc_inc   = (pc_reg == LAST_INDEX) ? '0 : pc_reg + AW'(1);
    assign loop_inc = (loop_start_reg == LAST_INDEX) ? '0 : loop_start_reg + AW'(1);
    assign stopped  = (status_reg == srs_pkg::ST_CMD_ERR) ||
                      (status_reg == srs_pkg::ST_NEST_ERR) ||
                      (status_reg == srs_pkg::ST_FINISHED);

    assign addr_ext  = 9'(recipe_address);
    assign ram_we    = in_fire && (operation == srs_pkg::OP_WRITE) &&
                       (addr_ext < 9'(RECIPE_DEPTH));
    assign ram_waddr = addr_ext[AW-1:0];
    assign ram_wdata = recipe_word;
    assign ram_raddr = aresetn ? pc_next : '0;

    // Next state
    always_comb begin
        pc_next         = pc_reg;
        tick_next       = tick_reg;
        loop_start_next = loop_start_reg;
        loop_rem_next   = loop_rem_reg;
        loop_act_next   = loop_act_reg;
        pend_next       = pend_reg;
        status_next     = status_reg;
        pos_next        = pos_reg;
        mtc_next        = mtc_reg;
        duty_next       = duty_reg;
        if (in_fire) begin
            unique case (operation)
                srs_pkg::OP_TICK: begin
                    if (status_reg == srs_pkg::ST_RUNNING ||
                        status_reg == srs_pkg::ST_MOVING) begin
                        unique case (cmd[7:5])
                            srs_pkg::OPC_WAIT: begin
                                if (tick_reg == {2'b00, par}) begin
                                    pc_next   = pc_inc;
                                    tick_next = '0;
                                end else begin
                                    tick_next = tick_reg + 7'd1;
                                end
                            end
                            srs_pkg::OPC_MOV: begin
                                if (par <= 5'(srs_pkg::POS_MAX)) begin
                                    duty_next = srs_pkg::duty_of(par_pos);
                                    if (tick_reg == target) begin
                                        status_next = srs_pkg::ST_RUNNING;
                                        pos_next    = par_pos;
                                        pc_next     = pc_inc;
                                        tick_next   = '0;
                                        if (pend_reg) begin
                                            status_next = srs_pkg::ST_PAUSED;
                                            pend_next   = 1'b0;
                                        end
                                    end else begin
                                        status_next = srs_pkg::ST_MOVING;
                                        tick_next   = tick_reg + 7'd1;
                                    end
                                end else begin
                                    status_next = srs_pkg::ST_CMD_ERR;
                                end
                            end
                            srs_pkg::OPC_LOOP: begin
                                if (loop_act_reg) begin
                                    status_next = srs_pkg::ST_NEST_ERR;
                                end else begin
                                    loop_start_next = pc_reg;
                                    loop_rem_next   = par;
                                    loop_act_next   = 1'b1;
                                    pc_next         = pc_inc;
                                end
                            end
                            srs_pkg::OPC_ENDLOOP: begin
                                if (loop_rem_reg == '0) begin
                                    loop_act_next = 1'b0;
                                    pc_next       = pc_inc;
                                end else begin
                                    loop_rem_next = loop_rem_reg - 5'd1;
                                    pc_next       = loop_inc;
                                end
                            end
                            srs_pkg::OPC_END: begin
                                status_next = srs_pkg::ST_FINISHED;
                            end
                            default: begin
                                status_next = srs_pkg::ST_CMD_ERR;
                            end
                        endcase
                    end else if (status_reg == srs_pkg::ST_MANUAL) begin
                        if (mtc_inc == man_ticks_reg) begin
                            mtc_next    = '0;
                            status_next = srs_pkg::ST_PAUSED;
                        end else begin
                            mtc_next = mtc_inc;
                        end
                    end
                end
                srs_pkg::OP_PAUSE: begin
                    if (status_reg == srs_pkg::ST_MOVING) begin
                        pend_next = 1'b1;
                    end else if (!stopped) begin
                        status_next = srs_pkg::ST_PAUSED;
                        mtc_next    = '0;
                    end
                end
                srs_pkg::OP_CONTINUE: begin
                    if (!stopped) begin
                        status_next = srs_pkg::ST_RUNNING;
                        mtc_next    = '0;
                    end
                end
                srs_pkg::OP_STEP_R: begin
                    if (status_reg == srs_pkg::ST_PAUSED && pos_reg != '0 &&
                        pos_reg <= srs_pkg::POS_MAX) begin
                        pos_next    = pos_reg - 3'd1;
                        status_next = srs_pkg::ST_MANUAL;
                        duty_next   = srs_pkg::duty_of(pos_reg - 3'd1);
                    end
                end
                srs_pkg::OP_STEP_L: begin
                    if (status_reg == srs_pkg::ST_PAUSED &&
                        pos_reg < srs_pkg::POS_MAX) begin
                        pos_next    = pos_reg + 3'd1;
                        status_next = srs_pkg::ST_MANUAL;
                        duty_next   = srs_pkg::duty_of(pos_reg + 3'd1);
                    end
                end
                srs_pkg::OP_RESTART: begin
                    status_next     = srs_pkg::ST_RUNNING;
                    pc_next         = '0;
                    tick_next       = '0;
                    loop_start_next = '0;
                    loop_rem_next   = '0;
                    loop_act_next   = 1'b0;
                    pend_next       = 1'b0;
                    pos_next        = '0;
                    mtc_next        = '0;
                end
                default: begin
                    // recipe writes and unused codes leave the channel state alone
                end
            endcase
        end
    end

    // Result of the request: state after it has been handled
    always_comb begin
        index_ext             = 9'(pc_next);
        result.duty_value     = duty_next;
        result.run_state      = status_next;
        result.servo_position = pos_next;
        result.program_index  = index_ext[srs_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= '0;
            tick_reg       <= '0;
            loop_start_reg <= '0;
            loop_rem_reg   <= '0;
            loop_act_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            status_reg     <= srs_pkg::ST_PAUSED;
            pos_reg        <= '0;
            mtc_reg        <= '0;
            duty_reg       <= '0;
            move_ticks_reg <= srs_pkg::MOVE_TICKS_RESET;
            man_ticks_reg  <= srs_pkg::MAN_TICKS_RESET;
            byp_hit_reg    <= 1'b0;
            valid_reg      <= '0;
        end else begin
            pc_reg         <= pc_next;
            tick_reg       <= tick_next;
            loop_start_reg <= loop_start_next;
            loop_rem_reg   <= loop_rem_next;
            loop_act_reg   <= loop_act_next;
            pend_reg       <= pend_next;
            status_reg     <= status_next;
            pos_reg        <= pos_next;
            mtc_reg        <= mtc_next;
            duty_reg       <= duty_next;
            byp_hit_reg    <= ram_we && (ram_waddr == ram_raddr);
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_write) begin
                if (cfg_index == srs_pkg::CFG_MOVE_TICKS) begin
                    move_ticks_reg <= cfg_data;
                end else if (cfg_index == srs_pkg::CFG_MANUAL_TICKS) begin
                    man_ticks_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        byp_word_reg <= ram_wdata;
    end

endmodule

/* hw/rtl/srs_out.sv */
// Output register with skid stage for the result channel.
module srs_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  srs_pkg::result_t              in_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output srs_pkg::result_t              m_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    srs_pkg::result_t out_reg, out_next;
    srs_pkg::result_t skid_reg, skid_next;
    logic             in_fire, out_take;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_take = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (in_fire) begin
            if (!out_valid_reg || out_take) begin
                out_next       = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_take) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* hw/rtl/servo_recipe_sequencer.sv */
// Top level of the servo recipe sequencer: recipe RAM, sequencer core, result buffer.
//
// One servo channel running a stored recipe of command bytes.
// Input channel (s_*): one request per item - tick, recipe write, pause,
//   continue, step right, step left or restart. Each request yields exactly
//   one result on the m_* channel: duty, run state, position, program index,
//   all as they stand once the request has been handled.
// Configuration channel (cfg_*): always ready; index 0 sets the ticks per
//   position step of a move, index 1 the length of a manual step. Write it
//   only while no request is in flight.
// Throughput: one request per cycle while s_ready is high. The recipe RAM is read
//   ahead at the next program index, so each cycle does one fetch and one update;
//   a write hitting the entry being fetched is bypassed.
// Each result lands in the output register, or in the skid stage if that one stalls.
// Stall: results wait in an output register with a skid stage behind it;
//   s_ready drops only when both are full, and nothing is lost or repeated.
// Reset (aresetn low, synchronous): state returns to paused at index 0,
//   registers take their reset values and every recipe entry reads as END
//   until written. No clearing pass is needed.
module servo_recipe_sequencer #(
    parameter int RECIPE_DEPTH = srs_pkg::RECIPE_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [srs_pkg::OP_W-1:0]          s_operation,
    input  logic [srs_pkg::ADDR_IN_W-1:0]     s_recipe_address,
    input  logic [srs_pkg::WORD_W-1:0]        s_recipe_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [srs_pkg::DUTY_W-1:0]        m_duty_value,
    output logic [2:0]                        m_run_state,
    output logic [srs_pkg::POS_W-1:0]         m_servo_position,
    output logic [srs_pkg::INDEX_W-1:0]       m_program_index,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srs_pkg::CFG_VAL_W-1:0]     cfg_data
);

    localparam int AW = $clog2(RECIPE_DEPTH);

    logic                       in_fire;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [srs_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [srs_pkg::WORD_W-1:0] ram_rdata;
    srs_pkg::result_t           core_result;
    srs_pkg::result_t           out_result;

    // Request accepted: advance the sequencer by one item
    assign in_fire   = s_valid && s_ready;
    // Register writes complete at once
    assign cfg_ready = 1'b1;

    srs_ram #(
        .WIDTH (srs_pkg::WORD_W),
        .DEPTH (RECIPE_DEPTH)
    ) u_recipe_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srs_core #(
        .RECIPE_DEPTH (RECIPE_DEPTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_fire        (in_fire),
        .operation      (s_operation),
        .recipe_address (s_recipe_address),
        .recipe_word    (s_recipe_word),
        .cfg_write      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .result         (core_result)
    );

    // Hold results here while the receiver stalls
    srs_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (core_result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (out_result)
    );

    assign m_duty_value     = out_result.duty_value;
    assign m_run_state      = out_result.run_state;
    assign m_servo_position = out_result.servo_position;
    assign m_program_index  = out_result.program_index;

endmodule

/* tb/servo_recipe_sequencer_tb.sv */
// Self-checking testbench of the servo recipe sequencer: directed requests, then random recipes.
module servo_recipe_sequencer_tb;
    import srs_pkg::*;

    // Operation code the block must ignore, and an opcode the recipe does not define.
    localparam logic [OP_W-1:0] OP_RESERVED   = 3'd7;
    localparam logic [2:0]      OPC_UNDEFINED = 3'd6;

    localparam int RECIPE_DEPTH   = RECIPE_DEPTH_DEFAULT;
    // Cycles in a row without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT    = 2000;
    // Random requests per configuration phase.
    localparam int PHASE_REQUESTS = 330;
    // Cycles to watch for stray results once everything expected has arrived.
    localparam int LATENCY_MARGIN = 4;

    // Channel state as it shows on the result port.
    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        status_t            run_state;
        logic [POS_W-1:0]   position;
        logic [INDEX_W-1:0] index;
    } chan_state_t;

    // One request; typed marks a row whose result is spelt out by hand.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [ADDR_IN_W-1:0] addr;
        logic [WORD_W-1:0]    word;
        logic                 typed;
        chan_state_t          want;
    } servo_req_t;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation      = '0;
    logic [ADDR_IN_W-1:0]  s_recipe_address = '0;
    logic [WORD_W-1:0]     s_recipe_word    = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [DUTY_W-1:0]     m_duty_value;
    logic [2:0]            m_run_state;
    logic [POS_W-1:0]      m_servo_position;
    logic [INDEX_W-1:0]    m_program_index;
    logic                  cfg_valid        = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [CFG_VAL_W-1:0]  cfg_data         = '0;

    // Predicted copy of the channel: recipe, sequencer, loop and servo state.
    logic [WORD_W-1:0]     recipe_img [RECIPE_DEPTH];
    logic [INDEX_W-1:0]    seq_pc;
    logic [TICK_W-1:0]     seq_ticks;
    logic [INDEX_W-1:0]    loop_head;
    logic [PARAM_W-1:0]    loop_passes;
    logic                  loop_on;
    logic                  hold_req;
    status_t               seq_status;
    logic [POS_W-1:0]      servo_pos;
    logic [MTICK_W-1:0]    manual_ticks_run;
    logic [DUTY_W-1:0]     duty_reg;
    logic [CFG_VAL_W-1:0]  move_ticks_cfg;
    logic [CFG_VAL_W-1:0]  manual_ticks_cfg;

    chan_state_t awaited_states [$];
    servo_req_t  directed_reqs [28];

    int mismatches        = 0;
    int requests_sent     = 0;
    int episodes_run      = 0;
    int quiet_cycles      = 0;
    int sender_idle_pct   = 30;
    int receiver_idle_pct = 46;

    servo_recipe_sequencer #(
        .RECIPE_DEPTH(RECIPE_DEPTH)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_recipe_address (s_recipe_address),
        .s_recipe_word    (s_recipe_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_duty_value     (m_duty_value),
        .m_run_state      (m_run_state),
        .m_servo_position (m_servo_position),
        .m_program_index  (m_program_index),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // PWM compare value for a position: 40 plus 32 per step.
    function automatic logic [DUTY_W-1:0] compare_value_at(input logic [POS_W-1:0] pos);
        return DUTY_W'(40 + 32 * int'(pos));
    endfunction

    // Errors and the finished state are left only through a restart.
    function automatic logic channel_halted();
        return seq_status inside {ST_CMD_ERR, ST_NEST_ERR, ST_FINISHED};
    endfunction

    function automatic servo_req_t plain_req(input logic [OP_W-1:0] op,
                                             input logic [ADDR_IN_W-1:0] addr,
                                             input logic [WORD_W-1:0] word);
        servo_req_t r;
        r       = '0;
        r.op    = op;
        r.addr  = addr;
        r.word  = word;
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic servo_req_t typed_req(input logic [OP_W-1:0] op,
                                             input logic [ADDR_IN_W-1:0] addr,
                                             input logic [WORD_W-1:0] word,
                                             input logic [DUTY_W-1:0] duty,
                                             input status_t st,
                                             input logic [POS_W-1:0] pos,
                                             input logic [INDEX_W-1:0] idx);
        servo_req_t r;
        r                = plain_req(op, addr, word);
        r.typed          = 1'b1;
        r.want.duty      = duty;
        r.want.run_state = st;
        r.want.position  = pos;
        r.want.index     = idx;
        return r;
    endfunction

    // A move or a wait with random content; a bad move turns up now and then.
    function automatic logic [WORD_W-1:0] motion_cmd();
        if ($urandom_range(1) == 0)
            return {OPC_MOV, ($urandom_range(39) == 0) ? PARAM_W'($urandom_range(31, 6))
                                                       : PARAM_W'($urandom_range(5))};
        return {OPC_WAIT, ($urandom_range(9) == 0) ? PARAM_W'($urandom_range(31))
                                                   : PARAM_W'($urandom_range(3))};
    endfunction

    // Run the command at the program counter for one tick.
    task automatic execute_step();
        logic [WORD_W-1:0]  cmd;
        logic [PARAM_W-1:0] par;
        logic [POS_W-1:0]   pos_gap;
        int                 span;
        logic [TICK_W-1:0]  target;
        cmd = recipe_img[seq_pc];
        par = cmd[PARAM_W-1:0];
        case (cmd[WORD_W-1:PARAM_W])
            OPC_WAIT: begin
                if (seq_ticks == TICK_W'(par)) begin
                    seq_pc    = seq_pc + INDEX_W'(1);
                    seq_ticks = '0;
                end else begin
                    seq_ticks = seq_ticks + TICK_W'(1);
                end
            end
            OPC_MOV: begin
                if (par <= PARAM_W'(POS_MAX)) begin
                    pos_gap  = (par[POS_W-1:0] > servo_pos) ? par[POS_W-1:0] - servo_pos
                                                            : servo_pos - par[POS_W-1:0];
                    span     = int'(move_ticks_cfg) * int'(pos_gap);
                    target   = span[TICK_W-1:0];
                    duty_reg = compare_value_at(par[POS_W-1:0]);
                    if (seq_ticks == target) begin
                        seq_status = ST_RUNNING;
                        servo_pos  = par[POS_W-1:0];
                        seq_pc     = seq_pc + INDEX_W'(1);
                        seq_ticks  = '0;
                        if (hold_req) begin
                            seq_status = ST_PAUSED;
                            hold_req   = 1'b0;
                        end
                    end else begin
                        seq_status = ST_MOVING;
                        seq_ticks  = seq_ticks + TICK_W'(1);
                    end
                end else begin
                    seq_status = ST_CMD_ERR;
                end
            end
            OPC_LOOP: begin
                if (loop_on) begin
                    seq_status = ST_NEST_ERR;
                end else begin
                    loop_head   = seq_pc;
                    loop_passes = par;
                    loop_on     = 1'b1;
                    seq_pc      = seq_pc + INDEX_W'(1);
                end
            end
            OPC_ENDLOOP: begin
                if (loop_passes == '0) begin
                    loop_on = 1'b0;
                    seq_pc  = seq_pc + INDEX_W'(1);
                end else begin
                    loop_passes = loop_passes - PARAM_W'(1);
                    seq_pc      = loop_head + INDEX_W'(1);
                end
            end
            OPC_END: seq_status = ST_FINISHED;
            default: seq_status = ST_CMD_ERR;
        endcase
    endtask

    // Apply one request to the predicted channel and return the state it shows after.
    task automatic next_channel_state(input logic [OP_W-1:0] op,
                                      input logic [ADDR_IN_W-1:0] addr,
                                      input logic [WORD_W-1:0] word,
                                      output chan_state_t shown);
        case (op)
            OP_TICK: begin
                if (seq_status == ST_RUNNING || seq_status == ST_MOVING) begin
                    execute_step();
                end else if (seq_status == ST_MANUAL) begin
                    manual_ticks_run = manual_ticks_run + MTICK_W'(1);
                    if (manual_ticks_run == manual_ticks_cfg) begin
                        manual_ticks_run = '0;
                        seq_status       = ST_PAUSED;
                    end
                end
            end
            OP_WRITE: recipe_img[addr] = word;
            OP_PAUSE: begin
                if (seq_status == ST_MOVING) begin
                    hold_req = 1'b1;
                end else if (!channel_halted()) begin
                    seq_status       = ST_PAUSED;
                    manual_ticks_run = '0;
                end
            end
            OP_CONTINUE: begin
                if (!channel_halted()) begin
                    seq_status       = ST_RUNNING;
                    manual_ticks_run = '0;
                end
            end
            OP_STEP_R: begin
                if (seq_status == ST_PAUSED && servo_pos != '0 && servo_pos <= POS_MAX) begin
                    servo_pos  = servo_pos - POS_W'(1);
                    seq_status = ST_MANUAL;
                    duty_reg   = compare_value_at(servo_pos);
                end
            end
            OP_STEP_L: begin
                if (seq_status == ST_PAUSED && servo_pos < POS_MAX) begin
                    servo_pos  = servo_pos + POS_W'(1);
                    seq_status = ST_MANUAL;
                    duty_reg   = compare_value_at(servo_pos);
                end
            end
            OP_RESTART: begin
                seq_status       = ST_RUNNING;
                seq_pc           = '0;
                seq_ticks        = '0;
                loop_head        = '0;
                loop_passes      = '0;
                loop_on          = 1'b0;
                hold_req         = 1'b0;
                servo_pos        = '0;
                manual_ticks_run = '0;
            end
            default: ;
        endcase
        shown.duty      = duty_reg;
        shown.run_state = seq_status;
        shown.position  = servo_pos;
        shown.index     = seq_pc;
    endtask

    // Present one request, hold it until accepted, then log its expected state.
    task automatic issue(input servo_req_t r);
        chan_state_t predicted;
        // Idle the request channel at random; each gap cycle drops valid.
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= r.op;
        s_recipe_address <= r.addr;
        s_recipe_word    <= r.word;
        do @(posedge aclk); while (!s_ready);
        next_channel_state(r.op, r.addr, r.word, predicted);
        awaited_states.push_back(r.typed ? r.want : predicted);
        requests_sent++;
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic await_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_states.size() != 0);
    endtask

    // Write both timing registers back to back; valid stays high across the pair.
    task automatic load_timing(input logic [CFG_VAL_W-1:0] move_ticks,
                               input logic [CFG_VAL_W-1:0] manual_ticks);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MOVE_TICKS;
        cfg_data  <= move_ticks;
        do @(posedge aclk); while (!cfg_ready);
        move_ticks_cfg = move_ticks;
        cfg_index <= CFG_MANUAL_TICKS;
        cfg_data  <= manual_ticks;
        do @(posedge aclk); while (!cfg_ready);
        manual_ticks_cfg = manual_ticks;
        cfg_valid <= 1'b0;
    endtask

    // Load a recipe, restart the channel and drive it with mostly ticks.
    task automatic run_episode();
        logic [WORD_W-1:0] prog [$];
        int                pick;
        int                steps;
        int                reps;
        logic              full_ring;
        logic [OP_W-1:0]   op;
        pick      = $urandom_range(99);
        full_ring = (pick < 12);
        if (full_ring) begin
            // Fill every slot with short commands and no END, so the index wraps.
            for (int i = 0; i < RECIPE_DEPTH; i++)
                prog.push_back(($urandom_range(4) == 0) ? {OPC_MOV, PARAM_W'($urandom_range(5))}
                                                        : {OPC_WAIT, PARAM_W'(0)});
        end else if (pick < 80) begin
            // Well-formed recipe: moves and waits, maybe one loop, then END.
            reps = $urandom_range(2);
            repeat (reps) prog.push_back(motion_cmd());
            if ($urandom_range(1) == 1) begin
                prog.push_back({OPC_LOOP, ($urandom_range(15) == 0) ? PARAM_W'($urandom_range(31))
                                                                    : PARAM_W'($urandom_range(3))});
                reps = $urandom_range(5, 1);
                repeat (reps) prog.push_back(motion_cmd());
                prog.push_back({OPC_ENDLOOP, PARAM_W'($urandom_range(31))});
            end
            reps = $urandom_range(3, 1);
            repeat (reps) prog.push_back(motion_cmd());
            prog.push_back({OPC_END, PARAM_W'($urandom_range(31))});
        end else begin
            // Noise: arbitrary command bytes, every opcode included.
            reps = $urandom_range(10, 2);
            repeat (reps) prog.push_back(WORD_W'($urandom_range(255)));
        end

        foreach (prog[i])
            issue(plain_req(OP_WRITE, ADDR_IN_W'(i), prog[i]));

        // Now and then hold off the next request until the channel has drained.
        if (episodes_run % 9 == 4)
            await_drain();

        issue(plain_req(OP_RESTART, ADDR_IN_W'($urandom_range(63)), WORD_W'($urandom_range(255))));

        steps = full_ring ? 400 : $urandom_range(120, 20);
        for (int n = 0; n < steps; n++) begin
            pick = $urandom_range(99);
            if (pick < 78)      op = OP_TICK;
            else if (pick < 82) op = OP_PAUSE;
            else if (pick < 86) op = OP_CONTINUE;
            else if (pick < 90) op = OP_STEP_R;
            else if (pick < 94) op = OP_STEP_L;
            else if (pick < 96) op = OP_RESTART;
            else if (pick < 99) op = OP_WRITE;
            else                op = OP_RESERVED;
            issue(plain_req(op, ADDR_IN_W'($urandom_range(63)), WORD_W'($urandom_range(255))));
            // Poke a stopped channel a little, then move on to the next recipe.
            if (channel_halted() && $urandom_range(2) == 0)
                break;
        end
        episodes_run++;
    endtask

    // One configuration phase: drain, set idling and timing, then random recipes.
    task automatic run_phase(input logic [CFG_VAL_W-1:0] move_ticks,
                             input logic [CFG_VAL_W-1:0] manual_ticks,
                             input int send_idle, input int recv_idle);
        int first;
        await_drain();
        sender_idle_pct   = send_idle;
        receiver_idle_pct = recv_idle;
        load_timing(move_ticks, manual_ticks);
        first = requests_sent;
        while (requests_sent - first < PHASE_REQUESTS)
            run_episode();
    endtask

    // Result sink: stall at random, per the current idling share.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        chan_state_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_states.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = awaited_states.pop_front();
                if (m_duty_value !== want.duty) begin
                    $error("duty_value: expected %0d, got %0d", want.duty, m_duty_value);
                    mismatches++;
                end
                if (m_run_state !== want.run_state) begin
                    $error("run_state: expected %0d, got %0d", want.run_state, m_run_state);
                    mismatches++;
                end
                if (m_servo_position !== want.position) begin
                    $error("servo_position: expected %0d, got %0d", want.position,
                           m_servo_position);
                    mismatches++;
                end
                if (m_program_index !== want.index) begin
                    $error("program_index: expected %0d, got %0d", want.index,
                           m_program_index);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        // Predicted channel after reset: empty recipe reads as END, paused at index 0.
        for (int i = 0; i < RECIPE_DEPTH; i++)
            recipe_img[i] = '0;
        seq_pc           = '0;
        seq_ticks        = '0;
        loop_head        = '0;
        loop_passes      = '0;
        loop_on          = 1'b0;
        hold_req         = 1'b0;
        seq_status       = ST_PAUSED;
        servo_pos        = '0;
        manual_ticks_run = '0;
        duty_reg         = '0;
        move_ticks_cfg   = MOVE_TICKS_RESET;
        manual_ticks_cfg = MAN_TICKS_RESET;

        // Directed requests under the reset timing (two ticks per step, two per manual step).
        directed_reqs = '{
            // Paused after reset, no duty commanded yet: a tick changes nothing.
            typed_req(OP_TICK, 6'd0, 8'd0, 8'd0, ST_PAUSED, 3'd0, 6'd0),
            typed_req(OP_CONTINUE, 6'h3F, 8'hFF, 8'd0, ST_RUNNING, 3'd0, 6'd0),
            // Unwritten recipe is END: finished, index stays put.
            typed_req(OP_TICK, 6'd0, 8'd0, 8'd0, ST_FINISHED, 3'd0, 6'd0),
            // Pause, the reserved operation and a write leave finished alone.
            typed_req(OP_PAUSE, 6'd0, 8'd0, 8'd0, ST_FINISHED, 3'd0, 6'd0),
            typed_req(OP_RESERVED, 6'h2A, 8'h55, 8'd0, ST_FINISHED, 3'd0, 6'd0),
            typed_req(OP_WRITE, 6'h3F, 8'hFF, 8'd0, ST_FINISHED, 3'd0, 6'd0),
            // Recipe: stray end of loop, move to 1, move out of range.
            plain_req(OP_WRITE, 6'd0, {OPC_ENDLOOP, 5'd0}),
            plain_req(OP_WRITE, 6'd1, {OPC_MOV, 5'd1}),
            plain_req(OP_WRITE, 6'd2, {OPC_MOV, 5'd31}),
            typed_req(OP_RESTART, 6'h15, 8'hAA, 8'd0, ST_RUNNING, 3'd0, 6'd0),
            plain_req(OP_TICK, 6'd0, 8'd0),
            plain_req(OP_TICK, 6'd0, 8'd0),
            // Pause during the move is held until the move ends.
            plain_req(OP_PAUSE, 6'd0, 8'd0),
            plain_req(OP_TICK, 6'd0, 8'd0),
            plain_req(OP_TICK, 6'd0, 8'd0),
            plain_req(OP_STEP_R, 6'd0, 8'd0),
            // Not paused any more, so this step is dropped.
            plain_req(OP_STEP_L, 6'd0, 8'd0),
            plain_req(OP_CONTINUE, 6'd0, 8'd0),
            typed_req(OP_TICK, 6'd0, 8'd0, 8'd40, ST_CMD_ERR, 3'd0, 6'd2),
            typed_req(OP_CONTINUE, 6'd0, 8'd0, 8'd40, ST_CMD_ERR, 3'd0, 6'd2),
            // Loop at index 0, then a second loop inside it.
            plain_req(OP_WRITE, 6'd0, {OPC_LOOP, 5'd0}),
            plain_req(OP_WRITE, 6'd1, {OPC_LOOP, 5'd31}),
            typed_req(OP_RESTART, 6'd0, 8'd0, 8'd40, ST_RUNNING, 3'd0, 6'd0),
            plain_req(OP_TICK, 6'd0, 8'd0),
            typed_req(OP_TICK, 6'd0, 8'd0, 8'd40, ST_NEST_ERR, 3'd0, 6'd1),
            // Undefined opcode.
            plain_req(OP_WRITE, 6'd0, {OPC_UNDEFINED, 5'd0}),
            typed_req(OP_RESTART, 6'd0, 8'd0, 8'd40, ST_RUNNING, 3'd0, 6'd0),
            typed_req(OP_TICK, 6'd0, 8'd0, 8'd40, ST_CMD_ERR, 3'd0, 6'd0)
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_reqs[i])
            issue(directed_reqs[i]);

        // Random recipes over several timings; sink idles more first, then the sender,
        // then neither side idles.
        run_phase(4'd1,  4'd15, 30, 46);
        run_phase(4'd15, 4'd1,  30, 46);
        run_phase(4'd0,  4'd0,  46, 30);
        run_phase(4'd3,  4'd5,  46, 30);
        run_phase(4'd15, 4'd15, 0,  0);
        run_phase(4'd1,  4'd1,  0,  0);

        // Drain, then keep watching for stray results.
        await_drain();
        repeat (LATENCY_MARGIN) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* servo_recipe_sequencer.f */
hw/rtl/srs_pkg.sv
hw/rtl/srs_ram.sv
hw/rtl/srs_core.sv
hw/rtl/srs_out.sv
hw/rtl/servo_recipe_sequencer.sv
tb/servo_recipe_sequencer_tb.sv
